// ===== rtl/core/ffua_pkg.sv =====
// shared types and constants of the first-fit unit allocator
// no dependencies; used by the channel interfaces and the top level
package ffua_pkg;

  localparam int unsigned REQ_BYTES_W = 25;
  localparam int unsigned UNIT_IDX_W  = 20;
  localparam int unsigned STATUS_W    = 2;
  // request bytes plus rounding term, before the shift by the unit size
  localparam int unsigned DIV_W       = REQ_BYTES_W + 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_BAD_FREE   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    op_t                    op;
    logic [REQ_BYTES_W-1:0] request_bytes;
    logic [UNIT_IDX_W-1:0]  payload_unit;
  } req_t;

  typedef struct packed {
    logic [UNIT_IDX_W-1:0] granted_unit;
    status_t               status;
  } rsp_t;

endpackage

// ===== rtl/core/ffua_req_if.sv =====
// request channel of the allocator: valid, ready and one request beat
// depends on ffua_pkg
interface ffua_req_if;
  logic          valid;
  logic          ready;
  ffua_pkg::req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/ffua_rsp_if.sv =====
// response channel of the allocator: valid, ready and one response beat
// depends on ffua_pkg
interface ffua_rsp_if;
  logic          valid;
  logic          ready;
  ffua_pkg::rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/first_fit_unit_allocator_top.sv =====
// first-fit unit allocator: segment and live-block tables in memories; needs ffua_pkg, ffua_*_if
// alloc: unit count, segment search, block slot scan, commit, on exact fit a shift of entries;
//   free: block slot scan, segment walk, merge, then a shift of entries to close or open a gap;
//   both end by loading the response register
// throughput: one request at a time; the next is taken once the response register is loaded
// reset: synchronous; then clears the live-block table, taking no request until done
module first_fit_unit_allocator_top #(
  parameter int unsigned ARENA_UNITS       = 1048576,
  parameter int unsigned UNIT_BYTES        = 16,
  parameter int unsigned MAX_FREE_SEGMENTS = 64,
  parameter int unsigned MAX_LIVE_BLOCKS   = 256
) (
  input logic       clk,
  input logic       rst,
  ffua_req_if.sink   req,
  ffua_rsp_if.source rsp
);

  // start of a segment or block, length of one
  localparam int unsigned SW   = $clog2(ARENA_UNITS);
  localparam int unsigned LW   = $clog2(ARENA_UNITS + 1);
  // segment table index and fill count
  localparam int unsigned IW   = $clog2(MAX_FREE_SEGMENTS);
  localparam int unsigned CW   = $clog2(MAX_FREE_SEGMENTS + 1);
  // live-block table index
  localparam int unsigned BIW  = $clog2(MAX_LIVE_BLOCKS);
  // log2 of the unit size; the user must keep the unit size a power of two, the block does not enforce it
  localparam int unsigned RMW  = $clog2(UNIT_BYTES);
  // unit count of a request
  localparam int unsigned NW   = ffua_pkg::DIV_W + 1;
  // width for payload-unit arithmetic
  localparam int unsigned XW   = (SW + 1 > ffua_pkg::UNIT_IDX_W) ? SW + 1
                                                                 : ffua_pkg::UNIT_IDX_W;

  typedef struct packed {
    logic [SW-1:0] start;
    logic [LW-1:0] len;
  } seg_t;

  typedef struct packed {
    logic          valid;
    logic [SW-1:0] start;
    logic [LW-1:0] len;
  } blk_t;

  typedef enum logic [16:0] {
    S_CLR     = 17'h00001,
    S_IDLE    = 17'h00002,
    S_DIV     = 17'h00004,
    S_ASRD    = 17'h00008,
    S_ASCHK   = 17'h00010,
    S_BRD     = 17'h00020,
    S_BCHK    = 17'h00040,
    S_ACOMMIT = 17'h00080,
    S_FJRD    = 17'h00100,
    S_FJCHK   = 17'h00200,
    S_FMERGE  = 17'h00400,
    S_RMRD    = 17'h00800,
    S_RMWR    = 17'h01000,
    S_INRD    = 17'h02000,
    S_INWR    = 17'h04000,
    S_OUT     = 17'h08000,
    S_SPARE   = 17'h10000
  } state_t;

  // memories
  seg_t seg_mem [MAX_FREE_SEGMENTS];
  blk_t blk_mem [MAX_LIVE_BLOCKS];

  logic          seg_we;
  logic [IW-1:0] seg_waddr;
  seg_t          seg_wdata;
  logic [IW-1:0] seg_raddr;
  seg_t          seg_rd;

  logic           blk_we;
  logic [BIW-1:0] blk_waddr;
  blk_t           blk_wdata;
  logic [BIW-1:0] blk_raddr;
  blk_t           blk_rd;

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    seg_rd <= seg_mem[seg_raddr];
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rd <= blk_mem[blk_raddr];
  end

  // control and working registers
  state_t                         state, state_next;
  logic [BIW-1:0]                 clr_idx, clr_idx_next;
  logic [CW-1:0]                  seg_count, seg_count_next;
  logic [IW-1:0]                  rover, rover_next;
  ffua_pkg::op_t                  op, op_next;
  logic [ffua_pkg::DIV_W-1:0]     dsh, dsh_next;
  logic [NW-1:0]                  need, need_next;
  logic [ffua_pkg::UNIT_IDX_W-1:0] payload, payload_next;
  logic [IW-1:0]                  idx, idx_next;
  logic [CW-1:0]                  scan_k, scan_k_next;
  seg_t                           fit, fit_next;
  logic [BIW-1:0]                 bslot, bslot_next;
  logic [SW-1:0]                  bs, bs_next;
  logic [LW-1:0]                  bl, bl_next;
  logic [CW-1:0]                  j, j_next;
  seg_t                           prev, prev_next;
  seg_t                           nxt, nxt_next;
  logic                           has_next, has_next_next;
  logic [CW-1:0]                  kk, kk_next;
  logic                           rm_alloc, rm_alloc_next;
  logic [ffua_pkg::UNIT_IDX_W-1:0] res_granted, res_granted_next;
  ffua_pkg::status_t              res_status, res_status_next;
  logic                           out_valid, out_valid_next;
  ffua_pkg::rsp_t                 out_data, out_data_next;

  // merge decisions of a free
  logic          prev_m, next_m;
  logic [IW-1:0] jm1;
  logic [LW:0]   prev_end, blk_end;
  // alloc commit values
  logic          exact;
  logic [LW-1:0] need_l, cut_len;
  logic [SW-1:0] bstart;
  logic          blk_hit;

  assign prev_end = (LW + 1)'(prev.start) + (LW + 1)'(prev.len);
  assign blk_end  = (LW + 1)'(bs) + (LW + 1)'(bl);
  assign prev_m   = (j != '0) && (prev_end == (LW + 1)'(bs));
  assign next_m   = has_next && (blk_end == (LW + 1)'(nxt.start));
  assign jm1      = IW'(j - CW'(1));

  assign exact   = (NW'(fit.len) == need);
  assign need_l  = need[LW-1:0];
  assign cut_len = fit.len - need_l;
  assign bstart  = exact ? fit.start : SW'(fit.start + SW'(cut_len));

  // a free matches on the payload unit, an alloc takes the first empty slot
  assign blk_hit = (op == ffua_pkg::OP_FREE)
                 ? (blk_rd.valid && ((XW'(blk_rd.start) + XW'(1)) == XW'(payload)))
                 : !blk_rd.valid;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    state_next       = state;
    clr_idx_next     = clr_idx;
    seg_count_next   = seg_count;
    rover_next       = rover;
    op_next          = op;
    dsh_next         = dsh;
    need_next        = need;
    payload_next     = payload;
    idx_next         = idx;
    scan_k_next      = scan_k;
    fit_next         = fit;
    bslot_next       = bslot;
    bs_next          = bs;
    bl_next          = bl;
    j_next           = j;
    prev_next        = prev;
    nxt_next         = nxt;
    has_next_next    = has_next;
    kk_next          = kk;
    rm_alloc_next    = rm_alloc;
    res_granted_next = res_granted;
    res_status_next  = res_status;
    out_data_next    = out_data;
    out_valid_next   = out_valid && !rsp.ready;

    seg_we    = 1'b0;
    seg_waddr = idx;
    seg_wdata = fit;
    seg_raddr = idx;
    blk_we    = 1'b0;
    blk_waddr = bslot;
    blk_wdata = blk_rd;
    blk_raddr = bslot;

    case (state)
      // sweep the live-block table empty, seed the arena segment
      S_CLR: begin
        blk_we          = 1'b1;
        blk_waddr       = clr_idx;
        blk_wdata       = '0;
        seg_we          = 1'b1;
        seg_waddr       = '0;
        seg_wdata.start = '0;
        seg_wdata.len   = LW'(ARENA_UNITS);
        clr_idx_next    = clr_idx + BIW'(1);
        if (clr_idx == BIW'(MAX_LIVE_BLOCKS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req.valid) begin
          op_next          = req.data.op;
          payload_next     = req.data.payload_unit;
          res_granted_next = '0;
          dsh_next         = ffua_pkg::DIV_W'(req.data.request_bytes)
                           + ffua_pkg::DIV_W'(UNIT_BYTES - 1);
          bslot_next       = '0;
          if (req.data.op == ffua_pkg::OP_ALLOC) begin
            state_next = S_DIV;
          end else begin
            state_next = S_BRD;
          end
        end
      end

      // unit count = ceil(bytes / unit) + 1, a shift by the unit size
      S_DIV: begin
        need_next   = NW'(dsh >> RMW) + NW'(1);
        scan_k_next = '0;
        idx_next    = (CW'(rover) < seg_count) ? rover : '0;
        if (seg_count == '0) begin
          res_status_next = ffua_pkg::ST_NO_SPACE;
          state_next      = S_OUT;
        end else begin
          state_next = S_ASRD;
        end
      end

      // first-fit search from the rover, wrapping around
      S_ASRD: begin
        seg_raddr  = idx;
        state_next = S_ASCHK;
      end

      S_ASCHK: begin
        if (NW'(seg_rd.len) >= need) begin
          fit_next   = seg_rd;
          bslot_next = '0;
          state_next = S_BRD;
        end else if (scan_k == seg_count - CW'(1)) begin
          res_status_next = ffua_pkg::ST_NO_SPACE;
          state_next      = S_OUT;
        end else begin
          scan_k_next = scan_k + CW'(1);
          idx_next    = ((CW'(idx) + CW'(1)) >= seg_count) ? '0 : idx + IW'(1);
          state_next  = S_ASRD;
        end
      end

      // live-block table scan, shared by both operations
      S_BRD: begin
        blk_raddr  = bslot;
        state_next = S_BCHK;
      end

      S_BCHK: begin
        if (blk_hit) begin
          if (op == ffua_pkg::OP_FREE) begin
            bs_next       = blk_rd.start;
            bl_next       = blk_rd.len;
            j_next        = '0;
            has_next_next = 1'b0;
            state_next    = S_FJRD;
          end else begin
            state_next = S_ACOMMIT;
          end
        end else if (bslot == BIW'(MAX_LIVE_BLOCKS - 1)) begin
          res_status_next = (op == ffua_pkg::OP_FREE) ? ffua_pkg::ST_BAD_FREE
                                                      : ffua_pkg::ST_TABLE_FULL;
          state_next      = S_OUT;
        end else begin
          bslot_next = bslot + BIW'(1);
          state_next = S_BRD;
        end
      end

      // record the block; exact fit drops the segment, else cut from its top
      S_ACOMMIT: begin
        blk_we           = 1'b1;
        blk_waddr        = bslot;
        blk_wdata.valid  = 1'b1;
        blk_wdata.start  = bstart;
        blk_wdata.len    = need_l;
        res_granted_next = ffua_pkg::UNIT_IDX_W'(XW'(bstart) + XW'(1));
        res_status_next  = ffua_pkg::ST_OK;
        if (exact) begin
          kk_next       = CW'(idx);
          rm_alloc_next = 1'b1;
          state_next    = S_RMRD;
        end else begin
          seg_we          = 1'b1;
          seg_waddr       = idx;
          seg_wdata.start = fit.start;
          seg_wdata.len   = cut_len;
          state_next      = S_OUT;
        end
      end

      // walk to the first segment at or above the freed block
      S_FJRD: begin
        if (j == seg_count) begin
          state_next = S_FMERGE;
        end else begin
          seg_raddr  = j[IW-1:0];
          state_next = S_FJCHK;
        end
      end

      S_FJCHK: begin
        if (seg_rd.start < bs) begin
          prev_next  = seg_rd;
          j_next     = j + CW'(1);
          state_next = S_FJRD;
        end else begin
          nxt_next      = seg_rd;
          has_next_next = 1'b1;
          state_next    = S_FMERGE;
        end
      end

      S_FMERGE: begin
        rm_alloc_next   = 1'b0;
        res_status_next = ffua_pkg::ST_OK;
        blk_waddr       = bslot;
        blk_wdata       = '0;
        if (prev_m && next_m) begin
          blk_we          = 1'b1;
          seg_we          = 1'b1;
          seg_waddr       = jm1;
          seg_wdata.start = prev.start;
          seg_wdata.len   = LW'(prev.len + bl + nxt.len);
          if (CW'(rover) >= j) begin
            rover_next = rover - IW'(1);
          end
          kk_next    = j;
          state_next = S_RMRD;
        end else if (prev_m) begin
          blk_we          = 1'b1;
          seg_we          = 1'b1;
          seg_waddr       = jm1;
          seg_wdata.start = prev.start;
          seg_wdata.len   = LW'(prev.len + bl);
          state_next      = S_OUT;
        end else if (next_m) begin
          blk_we          = 1'b1;
          seg_we          = 1'b1;
          seg_waddr       = j[IW-1:0];
          seg_wdata.start = bs;
          seg_wdata.len   = LW'(nxt.len + bl);
          state_next      = S_OUT;
        end else if (seg_count >= CW'(MAX_FREE_SEGMENTS)) begin
          // no room for a new segment: the block stays live
          res_status_next = ffua_pkg::ST_TABLE_FULL;
          state_next      = S_OUT;
        end else begin
          blk_we = 1'b1;
          if (seg_count == '0) begin
            rover_next = '0;
          end else if (CW'(rover) >= j) begin
            rover_next = rover + IW'(1);
          end
          kk_next    = seg_count;
          state_next = S_INRD;
        end
      end

      // close the gap at kk, reading and then writing each entry above it
      S_RMRD: begin
        if ((kk + CW'(1)) < seg_count) begin
          seg_raddr  = IW'(kk + CW'(1));
          state_next = S_RMWR;
        end else begin
          seg_count_next = seg_count - CW'(1);
          if (rm_alloc) begin
            rover_next = (CW'(idx) < (seg_count - CW'(1))) ? idx : '0;
          end
          state_next = S_OUT;
        end
      end

      S_RMWR: begin
        seg_we     = 1'b1;
        seg_waddr  = kk[IW-1:0];
        seg_wdata  = seg_rd;
        kk_next    = kk + CW'(1);
        state_next = S_RMRD;
      end

      // open a gap at j, moving entries up from the end
      S_INRD: begin
        if (kk > j) begin
          seg_raddr  = IW'(kk - CW'(1));
          state_next = S_INWR;
        end else begin
          seg_we          = 1'b1;
          seg_waddr       = j[IW-1:0];
          seg_wdata.start = bs;
          seg_wdata.len   = bl;
          seg_count_next  = seg_count + CW'(1);
          state_next      = S_OUT;
        end
      end

      S_INWR: begin
        seg_we     = 1'b1;
        seg_waddr  = kk[IW-1:0];
        seg_wdata  = seg_rd;
        kk_next    = kk - CW'(1);
        state_next = S_INRD;
      end

      // hand the response beat to the output register once it is free
      S_OUT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next             = 1'b1;
          out_data_next.granted_unit = res_granted;
          out_data_next.status       = res_status;
          state_next                 = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      seg_count <= CW'(1);
      rover     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      seg_count <= seg_count_next;
      rover     <= rover_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    dsh         <= dsh_next;
    need        <= need_next;
    payload     <= payload_next;
    idx         <= idx_next;
    scan_k      <= scan_k_next;
    fit         <= fit_next;
    bslot       <= bslot_next;
    bs          <= bs_next;
    bl          <= bl_next;
    j           <= j_next;
    prev        <= prev_next;
    nxt         <= nxt_next;
    has_next    <= has_next_next;
    kk          <= kk_next;
    rm_alloc    <= rm_alloc_next;
    res_granted <= res_granted_next;
    res_status  <= res_status_next;
    out_data    <= out_data_next;
  end

endmodule
